// ----- design/bmhq_pkg.sv -----
// Shared codes for the binary min-heap queue.
package bmhq_pkg;

  localparam logic KIND_INSERT  = 1'b0;
  localparam logic KIND_EXTRACT = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

endpackage

// ----- design/bmhq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bmhq_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bmhq_ctrl.sv -----
// Sift sequencer: walks the heap in RAM one level at a time.
module bmhq_ctrl #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 24,
  parameter int VALUE_BITS = 16,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int AW = $clog2(CAPACITY),
  localparam int EW = KEY_BITS + VALUE_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  kind,
  input  logic [KEY_BITS-1:0]   item_key,
  input  logic [VALUE_BITS-1:0] item_value,
  output logic                  res_done,
  input  logic                  res_free,
  output logic [KEY_BITS-1:0]   res_key,
  output logic [VALUE_BITS-1:0] res_value,
  output logic [1:0]            res_status,
  output logic [CW-1:0]         res_fill,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [EW-1:0]         wdata,
  output logic [AW-1:0]         raddr,
  input  logic [EW-1:0]         rdata
);
  import bmhq_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP      = 4'd1;
  localparam logic [3:0] S_UP_C    = 4'd2;
  localparam logic [3:0] S_EX_ROOT = 4'd3;
  localparam logic [3:0] S_EX_LAST = 4'd4;
  localparam logic [3:0] S_EX_CAP  = 4'd5;
  localparam logic [3:0] S_DN_L    = 4'd6;
  localparam logic [3:0] S_DN_R    = 4'd7;
  localparam logic [3:0] S_DN_C    = 4'd8;
  localparam logic [3:0] S_FIN     = 4'd9;

  logic [3:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         pos;
  logic [KEY_BITS-1:0]   ent_key;
  logic [VALUE_BITS-1:0] ent_val;
  logic [KEY_BITS-1:0]   lft_key;
  logic [VALUE_BITS-1:0] lft_val;
  logic                  has_right;

  logic [CW:0]           left;
  logic [CW:0]           right;
  logic [KEY_BITS-1:0]   rkey;
  logic                  up_move;
  logic                  pick_left;
  logic                  pick_right;
  logic [KEY_BITS-1:0]   best_key;
  logic                  accept;

  function automatic logic [AW-1:0] slot_addr(input logic [CW:0] s);
    logic [CW:0] t;
    t = s - {{CW{1'b0}}, 1'b1};
    return t[AW-1:0];
  endfunction

  assign left       = {pos, 1'b0};
  assign right      = left + {{CW{1'b0}}, 1'b1};
  assign rkey       = rdata[EW-1:VALUE_BITS];
  assign up_move    = ent_key < rkey;
  assign pick_left  = lft_key < ent_key;
  assign best_key   = pick_left ? lft_key : ent_key;
  assign pick_right = has_right && (rkey < best_key);
  assign in_stall   = (state != S_IDLE);
  assign accept     = in_valid && !in_stall;
  assign res_fill   = count;
  assign res_done   = (state == S_FIN) && res_free;

  always_comb begin
    we    = 1'b0;
    waddr = slot_addr({1'b0, pos});
    wdata = {ent_key, ent_val};
    raddr = '0;
    case (state)
      S_UP: begin
        if (pos == CW'(1)) begin
          we = 1'b1;
        end else begin
          raddr = slot_addr({2'b00, pos[CW-1:1]});
        end
      end
      S_UP_C: begin
        we = 1'b1;
        if (up_move) begin
          wdata = rdata;
        end
      end
      S_EX_LAST: raddr = slot_addr({1'b0, count});
      S_DN_L: begin
        if (left > {1'b0, count}) begin
          we = 1'b1;
        end else begin
          raddr = slot_addr(left);
        end
      end
      S_DN_R: raddr = slot_addr(right);
      S_DN_C: begin
        we = 1'b1;
        if (pick_right) begin
          wdata = rdata;
        end else if (pick_left) begin
          wdata = {lft_key, lft_val};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_key    <= '0;
            res_value  <= '0;
            res_status <= STATUS_OK;
            if (kind == KIND_INSERT) begin
              if (count == CW'(CAPACITY)) begin
                res_status <= STATUS_FULL;
                state      <= S_FIN;
              end else begin
                count   <= count + CW'(1);
                pos     <= count + CW'(1);
                ent_key <= item_key;
                ent_val <= item_value;
                state   <= S_UP;
              end
            end else if (count == '0) begin
              res_status <= STATUS_EMPTY;
              state      <= S_FIN;
            end else begin
              state <= S_EX_ROOT;
            end
          end
        end
        S_UP: state <= (pos == CW'(1)) ? S_FIN : S_UP_C;
        S_UP_C: begin
          if (up_move) begin
            pos   <= pos >> 1;
            state <= S_UP;
          end else begin
            state <= S_FIN;
          end
        end
        S_EX_ROOT: state <= S_EX_LAST;
        S_EX_LAST: begin
          res_key   <= rkey;
          res_value <= rdata[VALUE_BITS-1:0];
          state     <= S_EX_CAP;
        end
        S_EX_CAP: begin
          // take the last entry as the new root and drop one
          ent_key <= rkey;
          ent_val <= rdata[VALUE_BITS-1:0];
          count   <= count - CW'(1);
          pos     <= CW'(1);
          state   <= (count == CW'(1)) ? S_FIN : S_DN_L;
        end
        S_DN_L: state <= (left > {1'b0, count}) ? S_FIN : S_DN_R;
        S_DN_R: begin
          lft_key   <= rkey;
          lft_val   <= rdata[VALUE_BITS-1:0];
          has_right <= (right <= {1'b0, count});
          state     <= S_DN_C;
        end
        S_DN_C: begin
          if (pick_right) begin
            pos   <= right[CW-1:0];
            state <= S_DN_L;
          end else if (pick_left) begin
            pos   <= left[CW-1:0];
            state <= S_DN_L;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (res_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_FIN) |-> !we)
    else $error("RAM write outside a sift");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE)
    else $error("request accepted but sequencer stayed idle");
`endif

endmodule

// ----- design/binary_min_heap_queue.sv -----
// Binary min-heap priority queue: insert and extract-minimum on (key, value) entries held in one
// RAM. One request is worked at a time; the RAM gives one read and one write per cycle, so the
// sift sets how long a request takes: an insert grows with each level climbed and an extract
// with each level descended, while refused requests skip the sift. A finished result sits in an
// output register, so the next request is taken while it waits. No clearing pass after reset.
module binary_min_heap_queue #(
  parameter int CAPACITY   = 1024,
  parameter int KEY_BITS   = 24,
  parameter int VALUE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              kind,
  input  logic [KEY_BITS-1:0]               item_key,
  input  logic [VALUE_BITS-1:0]             item_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [KEY_BITS-1:0]               out_key,
  output logic [VALUE_BITS-1:0]             out_value,
  output logic [1:0]                        status,
  output logic [$clog2(CAPACITY + 1)-1:0]   fill_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int EW = KEY_BITS + VALUE_BITS;

  logic                  res_done;
  logic                  res_free;
  logic [KEY_BITS-1:0]   res_key;
  logic [VALUE_BITS-1:0] res_value;
  logic [1:0]            res_status;
  logic [CW-1:0]         res_fill;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [EW-1:0]         wdata;
  logic [AW-1:0]         raddr;
  logic [EW-1:0]         rdata;

  assign res_free = !out_valid || !out_stall;

  bmhq_ctrl #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .item_key  (item_key),
    .item_value(item_value),
    .res_done  (res_done),
    .res_free  (res_free),
    .res_key   (res_key),
    .res_value (res_value),
    .res_status(res_status),
    .res_fill  (res_fill),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .raddr     (raddr),
    .rdata     (rdata)
  );

  bmhq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_done) begin
      out_key    <= res_key;
      out_value  <= res_value;
      status     <= res_status;
      fill_count <= res_fill;
    end
  end

endmodule
